// File: design/xst_pkg.sv
// Shared types, character codes and sizing for the XML SAX tokeniser.
`default_nettype none

package xst_pkg;

    // Token text buffer sizing
    localparam int TEXT_BUF_DEPTH = 32;
    localparam int ADDR_W         = $clog2(TEXT_BUF_DEPTH);
    localparam int FILL_W         = $clog2(TEXT_BUF_DEPTH + 1);

    localparam logic [FILL_W-1:0] FILL_DEPTH     = FILL_W'(TEXT_BUF_DEPTH);
    localparam logic [FILL_W-1:0] FILL_NEAR_FULL = FILL_W'(TEXT_BUF_DEPTH - 2);

    // Character codes
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // Tokeniser states
    typedef enum logic [3:0] {
        ST_CHARS      = 4'd0,
        ST_ELEM_NAME  = 4'd1,
        ST_ELEM_OPEN  = 4'd2,
        ST_OPEN_EMPTY = 4'd3,
        ST_ATTR_NAME  = 4'd4,
        ST_WAIT_EQ    = 4'd5,
        ST_WAIT_QUOT  = 4'd6,
        ST_ATTR_VALUE = 4'd7,
        ST_CLOSE      = 4'd8,
        ST_CLOSE_NAME = 4'd9,
        ST_PI_CLOSE   = 4'd10,
        ST_ERROR      = 4'd11
    } t_pstate;

    // Event kinds on the result channel
    typedef enum logic [2:0] {
        EV_CHARS      = 3'd0,
        EV_START_ELEM = 3'd1,
        EV_END_NAMED  = 3'd2,
        EV_END_EMPTY  = 3'd3,
        EV_START_ATTR = 3'd4,
        EV_END_ATTR   = 3'd5,
        EV_ERROR      = 3'd6
    } t_event;

    // Per-request sequencer phases
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_PRE,
        SEQ_HANDLE,
        SEQ_END_ATTR,
        SEQ_CHUNK,
        SEQ_TXT_RD,
        SEQ_TXT
    } t_seq;

    // What a character does to the buffer
    typedef enum logic [1:0] {
        FL_NONE,
        FL_TEXT,
        FL_SINGLE
    } t_flush;

    // Decoded action for one character
    typedef struct packed {
        t_pstate pstate;
        logic    in_pi;
        logic    apos;
        logic    append;
        t_flush  flush;
        t_event  kind;
        logic    clear_fill;
        logic    end_attr;
    } t_action;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

endpackage

`default_nettype wire

// File: design/xst_intf.sv
// Valid/ready channel interfaces for the tokeniser's character and event streams.
`default_nettype none

interface xst_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       chunk_end;

    modport source (output valid, output char_byte, output chunk_end, input ready);
    modport sink   (input valid, input char_byte, input chunk_end, output ready);
endinterface

interface xst_evt_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_kind;
    logic       has_text;
    logic [7:0] text_byte;
    logic       last;

    modport source (output valid, output event_kind, output has_text, output text_byte,
                    output last, input ready);
    modport sink   (input valid, input event_kind, input has_text, input text_byte,
                    input last, output ready);
endinterface

`default_nettype wire

// File: design/xml_sax_tokenizer_top.sv
// XML SAX tokeniser: one character per request in, a run of event bytes out.
//
// One character is taken per request; the block works on it alone and accepts
// the next once all its events have been handed to the event register. A
// character that only appends to the token buffer, moves the tokeniser without
// emitting, or raises one event without text is accepted in SEQ_IDLE and
// handled in SEQ_HANDLE. A flush of buffered bytes first reads the text memory
// to prime it, then hands on one byte per cycle while the event register is
// free. The end-of-attribute event takes a step of its own. A flush at the end
// of a chunk has a SEQ_CHUNK step before it, and the early flush of a nearly
// full buffer a SEQ_PRE step. A stall on the event channel holds the sequencer
// wherever it loads the event register. The text memory has a single write
// port and a single read port: each byte is written once on arrival and read
// once on its flush. Characters sent after an error are accepted and dropped
// until reset. The text memory needs no clearing after reset: only entries
// written since the last flush are read.
`default_nettype none

module xml_sax_tokenizer_top (
    input  wire           i_clk,
    input  wire           i_rst_n,
    xst_char_if.sink      i_char,
    xst_evt_if.source     o_evt
);

    // Token text memory
    logic [7:0] r_text_mem [xst_pkg::TEXT_BUF_DEPTH];
    logic [7:0] r_rd_data;

    // Tokeniser state
    xst_pkg::t_pstate r_pstate, n_pstate;
    logic [xst_pkg::FILL_W-1:0] r_fill, n_fill;
    logic r_in_pi, n_in_pi;
    logic r_apos, n_apos;

    // Request sequencer
    xst_pkg::t_seq r_seq, n_seq;
    xst_pkg::t_seq r_ret, n_ret;
    logic [7:0] r_char;
    logic       r_chunk;
    logic [xst_pkg::ADDR_W-1:0] r_idx, n_idx;
    logic [xst_pkg::ADDR_W-1:0] r_txt_last, n_txt_last;
    xst_pkg::t_event r_txt_kind, n_txt_kind;

    // Event output register
    logic            r_out_valid;
    xst_pkg::t_event r_out_kind;
    logic            r_out_has;
    logic [7:0]      r_out_byte;
    logic            r_out_last;

    logic            w_accept;
    logic            w_out_free;
    logic            w_load;
    xst_pkg::t_event w_load_kind;
    logic            w_load_has;
    logic [7:0]      w_load_byte;
    logic            w_load_last;
    logic            w_wr_en;
    logic            w_rd_en;
    logic [xst_pkg::ADDR_W-1:0] w_rd_addr;
    logic [xst_pkg::FILL_W-1:0] w_hfill;
    logic            w_chunk_go;
    xst_pkg::t_seq   w_after;
    xst_pkg::t_action w_act;

    assign w_accept   = i_char.valid && i_char.ready;
    assign w_out_free = !r_out_valid || o_evt.ready;

    assign i_char.ready     = (r_seq == xst_pkg::SEQ_IDLE);
    assign o_evt.valid      = r_out_valid;
    assign o_evt.event_kind = r_out_kind;
    assign o_evt.has_text   = r_out_has;
    assign o_evt.text_byte  = r_out_byte;
    assign o_evt.last       = r_out_last;

    // Apply a buffer flush in the current state; an empty element name halts
    function automatic xst_pkg::t_action flush_into(
        input xst_pkg::t_action           a_in,
        input xst_pkg::t_pstate           st,
        input logic [xst_pkg::FILL_W-1:0] fill,
        input logic                       in_pi
    );
        xst_pkg::t_action a;
        a = a_in;
        a.clear_fill = 1'b1;
        case (st)
            xst_pkg::ST_CHARS, xst_pkg::ST_ATTR_VALUE: begin
                a.flush = xst_pkg::FL_TEXT;
                a.kind  = xst_pkg::EV_CHARS;
            end
            xst_pkg::ST_ELEM_NAME: begin
                if (fill == '0) begin
                    a.flush  = xst_pkg::FL_SINGLE;
                    a.kind   = xst_pkg::EV_ERROR;
                    a.pstate = xst_pkg::ST_ERROR;
                end else if (!in_pi) begin
                    a.flush = xst_pkg::FL_TEXT;
                    a.kind  = xst_pkg::EV_START_ELEM;
                end
            end
            xst_pkg::ST_OPEN_EMPTY: begin
                a.flush = xst_pkg::FL_SINGLE;
                a.kind  = xst_pkg::EV_END_EMPTY;
            end
            xst_pkg::ST_ATTR_NAME: begin
                a.flush = (fill == '0) ? xst_pkg::FL_SINGLE : xst_pkg::FL_TEXT;
                a.kind  = xst_pkg::EV_START_ATTR;
            end
            xst_pkg::ST_CLOSE_NAME: begin
                a.flush = (fill == '0) ? xst_pkg::FL_SINGLE : xst_pkg::FL_TEXT;
                a.kind  = xst_pkg::EV_END_NAMED;
            end
            default: ;
        endcase
        return a;
    endfunction

    // Raise an error event and halt
    function automatic xst_pkg::t_action raise_into(input xst_pkg::t_action a_in);
        xst_pkg::t_action a;
        a = a_in;
        a.flush  = xst_pkg::FL_SINGLE;
        a.kind   = xst_pkg::EV_ERROR;
        a.pstate = xst_pkg::ST_ERROR;
        return a;
    endfunction

    // Decode the held character against the tokeniser state
    always_comb begin
        w_act            = '0;
        w_act.pstate     = r_pstate;
        w_act.in_pi      = r_in_pi;
        w_act.apos       = r_apos;
        w_act.flush      = xst_pkg::FL_NONE;
        w_act.kind       = xst_pkg::EV_CHARS;
        unique case (r_pstate)
            xst_pkg::ST_CHARS: begin
                if (r_char == xst_pkg::CH_LT) begin
                    w_act        = flush_into(w_act, r_pstate, r_fill, r_in_pi);
                    w_act.pstate = xst_pkg::ST_ELEM_NAME;
                    w_act.in_pi  = 1'b0;
                end else begin
                    w_act.append = 1'b1;
                end
            end
            xst_pkg::ST_ELEM_NAME: begin
                if (xst_pkg::is_space(r_char)) begin
                    w_act.pstate = xst_pkg::ST_ELEM_OPEN;
                    w_act        = flush_into(w_act, r_pstate, r_fill, r_in_pi);
                end else if (r_char == xst_pkg::CH_GT) begin
                    w_act.pstate = xst_pkg::ST_CHARS;
                    w_act        = flush_into(w_act, r_pstate, r_fill, r_in_pi);
                end else if (r_char == xst_pkg::CH_SLASH) begin
                    if (r_fill != '0) begin
                        w_act.pstate = xst_pkg::ST_OPEN_EMPTY;
                        w_act        = flush_into(w_act, r_pstate, r_fill, r_in_pi);
                    end else begin
                        w_act.pstate = xst_pkg::ST_CLOSE_NAME;
                    end
                end else if (r_char == xst_pkg::CH_QMARK && r_fill == '0) begin
                    w_act.in_pi = 1'b1;
                end else begin
                    w_act.append = 1'b1;
                end
            end
            xst_pkg::ST_ELEM_OPEN: begin
                if (xst_pkg::is_space(r_char)) begin
                    w_act.pstate = r_pstate;
                end else if (r_char == xst_pkg::CH_GT) begin
                    if (!r_in_pi) w_act.pstate = xst_pkg::ST_CHARS;
                    else          w_act = raise_into(w_act);
                end else if (r_char == xst_pkg::CH_QMARK) begin
                    if (r_in_pi) w_act.pstate = xst_pkg::ST_PI_CLOSE;
                    else         w_act = raise_into(w_act);
                end else if (r_char == xst_pkg::CH_SLASH) begin
                    w_act.pstate = xst_pkg::ST_OPEN_EMPTY;
                end else begin
                    w_act.append = 1'b1;
                    w_act.pstate = xst_pkg::ST_ATTR_NAME;
                end
            end
            xst_pkg::ST_OPEN_EMPTY: begin
                if (xst_pkg::is_space(r_char)) begin
                    w_act.pstate = r_pstate;
                end else if (r_char == xst_pkg::CH_GT) begin
                    w_act        = flush_into(w_act, r_pstate, r_fill, r_in_pi);
                    w_act.pstate = xst_pkg::ST_CHARS;
                end else begin
                    w_act = raise_into(w_act);
                end
            end
            xst_pkg::ST_ATTR_NAME: begin
                if (xst_pkg::is_space(r_char)) begin
                    w_act        = flush_into(w_act, r_pstate, r_fill, r_in_pi);
                    w_act.pstate = xst_pkg::ST_WAIT_EQ;
                end else if (r_char == xst_pkg::CH_EQ) begin
                    w_act        = flush_into(w_act, r_pstate, r_fill, r_in_pi);
                    w_act.pstate = xst_pkg::ST_WAIT_QUOT;
                end else begin
                    w_act.append = 1'b1;
                end
            end
            xst_pkg::ST_WAIT_EQ: begin
                if (xst_pkg::is_space(r_char)) begin
                    w_act.pstate = r_pstate;
                end else if (r_char == xst_pkg::CH_EQ) begin
                    w_act.pstate = xst_pkg::ST_WAIT_QUOT;
                end else begin
                    w_act = raise_into(w_act);
                end
            end
            xst_pkg::ST_WAIT_QUOT: begin
                if (xst_pkg::is_space(r_char)) begin
                    w_act.pstate = r_pstate;
                end else if (r_char == xst_pkg::CH_DQUOTE) begin
                    w_act.pstate = xst_pkg::ST_ATTR_VALUE;
                    w_act.apos   = 1'b0;
                end else if (r_char == xst_pkg::CH_APOS) begin
                    w_act.pstate = xst_pkg::ST_ATTR_VALUE;
                    w_act.apos   = 1'b1;
                end else begin
                    w_act = raise_into(w_act);
                end
            end
            xst_pkg::ST_ATTR_VALUE: begin
                if ((r_char == xst_pkg::CH_DQUOTE && !r_apos) ||
                    (r_char == xst_pkg::CH_APOS && r_apos)) begin
                    w_act          = flush_into(w_act, r_pstate, r_fill, r_in_pi);
                    w_act.end_attr = 1'b1;
                    w_act.pstate   = xst_pkg::ST_ELEM_OPEN;
                end else begin
                    w_act.append = 1'b1;
                end
            end
            xst_pkg::ST_CLOSE: begin
                if (xst_pkg::is_space(r_char)) begin
                    w_act.pstate = r_pstate;
                end else if (r_char == xst_pkg::CH_GT) begin
                    w_act.pstate = xst_pkg::ST_CHARS;
                end else begin
                    w_act = raise_into(w_act);
                end
            end
            xst_pkg::ST_CLOSE_NAME: begin
                if (xst_pkg::is_space(r_char)) begin
                    w_act        = flush_into(w_act, r_pstate, r_fill, r_in_pi);
                    w_act.pstate = xst_pkg::ST_CLOSE;
                end else if (r_char == xst_pkg::CH_GT) begin
                    w_act        = flush_into(w_act, r_pstate, r_fill, r_in_pi);
                    w_act.pstate = xst_pkg::ST_CHARS;
                end else begin
                    w_act.append = 1'b1;
                end
            end
            xst_pkg::ST_PI_CLOSE: begin
                if (r_char == xst_pkg::CH_GT) w_act.pstate = xst_pkg::ST_CHARS;
                else                          w_act = raise_into(w_act);
            end
            default: begin
                w_act.pstate = xst_pkg::ST_ERROR;
            end
        endcase
    end

    // Fill level after the decoded action
    always_comb begin
        if (w_act.clear_fill) begin
            w_hfill = '0;
        end else if (w_act.append && (r_fill < xst_pkg::FILL_DEPTH)) begin
            w_hfill = r_fill + xst_pkg::FILL_W'(1);
        end else begin
            w_hfill = r_fill;
        end
    end

    assign w_chunk_go = r_chunk && (w_hfill != '0) &&
                        ((w_act.pstate == xst_pkg::ST_CHARS) ||
                         (w_act.pstate == xst_pkg::ST_ATTR_VALUE));

    always_comb begin
        if (w_act.end_attr)  w_after = xst_pkg::SEQ_END_ATTR;
        else if (w_chunk_go) w_after = xst_pkg::SEQ_CHUNK;
        else                 w_after = xst_pkg::SEQ_IDLE;
    end

    // Sequencer: next phase, state update, memory and event register control
    always_comb begin
        n_seq       = r_seq;
        n_ret       = r_ret;
        n_pstate    = r_pstate;
        n_fill      = r_fill;
        n_in_pi     = r_in_pi;
        n_apos      = r_apos;
        n_idx       = r_idx;
        n_txt_last  = r_txt_last;
        n_txt_kind  = r_txt_kind;
        w_load      = 1'b0;
        w_load_kind = xst_pkg::EV_CHARS;
        w_load_has  = 1'b0;
        w_load_byte = 8'h00;
        w_load_last = 1'b1;
        w_wr_en     = 1'b0;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_idx;
        unique case (r_seq)
            xst_pkg::SEQ_IDLE: begin
                if (w_accept) begin
                    if (r_pstate >= xst_pkg::ST_ERROR) begin
                        n_seq = xst_pkg::SEQ_IDLE;
                    end else if (r_fill > xst_pkg::FILL_NEAR_FULL) begin
                        n_seq = xst_pkg::SEQ_PRE;
                    end else begin
                        n_seq = xst_pkg::SEQ_HANDLE;
                    end
                end
            end
            xst_pkg::SEQ_PRE: begin
                // Flush a nearly full text buffer early; elsewhere it is an error
                if (r_pstate == xst_pkg::ST_CHARS || r_pstate == xst_pkg::ST_ATTR_VALUE) begin
                    n_txt_last = xst_pkg::ADDR_W'(r_fill - xst_pkg::FILL_W'(1));
                    n_idx      = '0;
                    n_txt_kind = xst_pkg::EV_CHARS;
                    n_ret      = xst_pkg::SEQ_HANDLE;
                    n_fill     = '0;
                    n_seq      = xst_pkg::SEQ_TXT_RD;
                end else if (w_out_free) begin
                    w_load      = 1'b1;
                    w_load_kind = xst_pkg::EV_ERROR;
                    n_pstate    = xst_pkg::ST_ERROR;
                    n_seq       = xst_pkg::SEQ_IDLE;
                end
            end
            xst_pkg::SEQ_HANDLE: begin
                if (w_act.flush != xst_pkg::FL_SINGLE || w_out_free) begin
                    n_pstate = w_act.pstate;
                    n_in_pi  = w_act.in_pi;
                    n_apos   = w_act.apos;
                    n_fill   = w_hfill;
                    w_wr_en  = w_act.append && (r_fill < xst_pkg::FILL_DEPTH);
                    if (w_act.flush == xst_pkg::FL_SINGLE) begin
                        w_load      = 1'b1;
                        w_load_kind = w_act.kind;
                    end
                    if (w_act.flush == xst_pkg::FL_TEXT && r_fill != '0) begin
                        n_txt_last = xst_pkg::ADDR_W'(r_fill - xst_pkg::FILL_W'(1));
                        n_idx      = '0;
                        n_txt_kind = w_act.kind;
                        n_ret      = w_after;
                        n_seq      = xst_pkg::SEQ_TXT_RD;
                    end else begin
                        n_seq = w_after;
                    end
                end
            end
            xst_pkg::SEQ_END_ATTR: begin
                if (w_out_free) begin
                    w_load      = 1'b1;
                    w_load_kind = xst_pkg::EV_END_ATTR;
                    n_seq       = xst_pkg::SEQ_IDLE;
                end
            end
            xst_pkg::SEQ_CHUNK: begin
                // Flush pending text at the end of a chunk
                n_txt_last = xst_pkg::ADDR_W'(r_fill - xst_pkg::FILL_W'(1));
                n_idx      = '0;
                n_txt_kind = xst_pkg::EV_CHARS;
                n_ret      = xst_pkg::SEQ_IDLE;
                n_fill     = '0;
                n_seq      = xst_pkg::SEQ_TXT_RD;
            end
            xst_pkg::SEQ_TXT_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_idx;
                n_seq     = xst_pkg::SEQ_TXT;
            end
            xst_pkg::SEQ_TXT: begin
                // Hand one byte on and prefetch the next
                if (w_out_free) begin
                    w_load      = 1'b1;
                    w_load_kind = r_txt_kind;
                    w_load_has  = 1'b1;
                    w_load_byte = r_rd_data;
                    w_load_last = (r_idx == r_txt_last);
                    if (r_idx == r_txt_last) begin
                        n_seq = r_ret;
                    end else begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = r_idx + xst_pkg::ADDR_W'(1);
                        n_idx     = r_idx + xst_pkg::ADDR_W'(1);
                    end
                end
            end
            default: begin
                n_seq = xst_pkg::SEQ_IDLE;
            end
        endcase
    end

    // Text memory: append at the fill level, registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_text_mem[r_fill[xst_pkg::ADDR_W-1:0]] <= r_char;
        end
        if (w_rd_en) begin
            r_rd_data <= r_text_mem[w_rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= xst_pkg::SEQ_IDLE;
            r_ret       <= xst_pkg::SEQ_IDLE;
            r_pstate    <= xst_pkg::ST_CHARS;
            r_fill      <= '0;
            r_in_pi     <= 1'b0;
            r_apos      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_seq    <= n_seq;
            r_ret    <= n_ret;
            r_pstate <= n_pstate;
            r_fill   <= n_fill;
            r_in_pi  <= n_in_pi;
            r_apos   <= n_apos;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_evt.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: held request, flush cursor, event register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_char  <= i_char.char_byte;
            r_chunk <= i_char.chunk_end;
        end
        r_idx      <= n_idx;
        r_txt_last <= n_txt_last;
        r_txt_kind <= n_txt_kind;
        if (w_load) begin
            r_out_kind <= w_load_kind;
            r_out_has  <= w_load_has;
            r_out_byte <= w_load_byte;
            r_out_last <= w_load_last;
        end
    end

endmodule

`default_nettype wire

// File: tb/sv/tb_xml_sax_tokenizer_top.sv
// Self-checking testbench for the XML SAX tokeniser: shadow tokeniser against scripted and random XML.
module tb_xml_sax_tokenizer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import xst_pkg::*;

    localparam int          CYCLE_LIMIT   = 300000;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          REPORT_CAP    = 60;
    localparam int unsigned PHASE_CHARS   = 135;
    localparam logic [7:0]  CH_FILL       = 8'h78;

    // One event byte as seen on the result channel
    typedef struct packed {
        t_event     kind;
        logic       has_text;
        logic [7:0] text_byte;
        logic       last;
    } evt_t;

    // Ways of driving the tokeniser into its sticky error state
    typedef enum logic [3:0] {
        ER_EMPTY_NAME,
        ER_NAME_OVERFLOW,
        ER_NO_EQUALS,
        ER_BAD_EMPTY_CLOSE,
        ER_PI_PLAIN_CLOSE,
        ER_QMARK_NO_PI,
        ER_BAD_CLOSE,
        ER_BAD_PI_CLOSE,
        ER_NO_QUOTE
    } err_route_t;

    logic i_clk;
    logic i_rst_n;

    xst_char_if chr_if ();
    xst_evt_if  evt_if ();

    xml_sax_tokenizer_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (chr_if),
        .o_evt   (evt_if)
    );

    // Shadow tokeniser state
    t_pstate     tok_state;
    logic [7:0]  tok_text [TEXT_BUF_DEPTH];
    int unsigned tok_fill;
    bit          tok_in_pi;
    bit          tok_apos;

    evt_t char_events [$];
    evt_t expected_events [$];

    int unsigned err_count    = 0;
    int unsigned cycle_count  = 0;
    int unsigned chars_sent   = 0;
    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;

    // ------------------------------------------------------------------
    // Shadow tokeniser
    // ------------------------------------------------------------------

    function automatic bit is_blank(input logic [7:0] c);
        case (c)
            CH_SPACE, CH_TAB, CH_CR, CH_LF: return 1'b1;
            default:                        return 1'b0;
        endcase
    endfunction

    function automatic void push_event(input t_event kind, input logic has,
                                       input logic [7:0] b, input logic lst);
        evt_t e;
        e.kind      = kind;
        e.has_text  = has;
        e.text_byte = b;
        e.last      = lst;
        char_events.push_back(e);
    endfunction

    function automatic void raise_error();
        push_event(EV_ERROR, 1'b0, 8'h00, 1'b1);
        tok_state = ST_ERROR;
    endfunction

    // Emit the buffered token, one byte per event
    function automatic void flush_text(input t_event kind);
        for (int unsigned i = 0; i < tok_fill && i < TEXT_BUF_DEPTH; i++) begin
            push_event(kind, 1'b1, tok_text[i], (i + 1 == tok_fill));
        end
    endfunction

    // Close the current token; returns 1 if an empty element name killed the parse
    function automatic bit flush_token();
        bit err;
        err = 1'b0;
        case (tok_state)
            ST_CHARS, ST_ATTR_VALUE: begin
                flush_text(EV_CHARS);
            end
            ST_ELEM_NAME: begin
                if (tok_fill == 0) begin
                    raise_error();
                    err = 1'b1;
                end else if (!tok_in_pi) begin
                    flush_text(EV_START_ELEM);
                end
            end
            ST_OPEN_EMPTY: begin
                push_event(EV_END_EMPTY, 1'b0, 8'h00, 1'b1);
            end
            ST_ATTR_NAME: begin
                if (tok_fill == 0) push_event(EV_START_ATTR, 1'b0, 8'h00, 1'b1);
                else flush_text(EV_START_ATTR);
            end
            ST_CLOSE_NAME: begin
                if (tok_fill == 0) push_event(EV_END_NAMED, 1'b0, 8'h00, 1'b1);
                else flush_text(EV_END_NAMED);
            end
            default: begin
            end
        endcase
        tok_fill = 0;
        return err;
    endfunction

    function automatic void append_char(input logic [7:0] c);
        if (tok_fill < TEXT_BUF_DEPTH) begin
            tok_text[tok_fill] = c;
            tok_fill++;
        end
    endfunction

    // Advance the shadow tokeniser by one character; events land in char_events
    function automatic void tokenise_char(input logic [7:0] c, input bit ce);
        char_events.delete();
        if (tok_state == ST_ERROR) return;

        // nearly full buffer: text drains early, anything else is fatal
        if (tok_fill > TEXT_BUF_DEPTH - 2) begin
            if (tok_state == ST_CHARS || tok_state == ST_ATTR_VALUE) begin
                void'(flush_token());
            end else begin
                raise_error();
                return;
            end
        end

        case (tok_state)
            ST_CHARS: begin
                if (c == CH_LT) begin
                    void'(flush_token());
                    tok_state = ST_ELEM_NAME;
                    tok_in_pi = 1'b0;
                end else begin
                    append_char(c);
                end
            end
            ST_ELEM_NAME: begin
                if (is_blank(c)) begin
                    if (!flush_token()) tok_state = ST_ELEM_OPEN;
                end else if (c == CH_GT) begin
                    if (!flush_token()) tok_state = ST_CHARS;
                end else if (c == CH_SLASH) begin
                    if (tok_fill != 0) begin
                        void'(flush_token());
                        tok_state = ST_OPEN_EMPTY;
                    end else begin
                        tok_state = ST_CLOSE_NAME;
                    end
                end else if (c == CH_QMARK && tok_fill == 0) begin
                    tok_in_pi = 1'b1;
                end else begin
                    append_char(c);
                end
            end
            ST_ELEM_OPEN: begin
                if (c == CH_GT) begin
                    if (tok_in_pi) raise_error();
                    else tok_state = ST_CHARS;
                end else if (c == CH_QMARK) begin
                    if (tok_in_pi) tok_state = ST_PI_CLOSE;
                    else raise_error();
                end else if (c == CH_SLASH) begin
                    tok_state = ST_OPEN_EMPTY;
                end else if (!is_blank(c)) begin
                    append_char(c);
                    tok_state = ST_ATTR_NAME;
                end
            end
            ST_OPEN_EMPTY: begin
                if (c == CH_GT) begin
                    void'(flush_token());
                    tok_state = ST_CHARS;
                end else if (!is_blank(c)) begin
                    raise_error();
                end
            end
            ST_ATTR_NAME: begin
                if (is_blank(c)) begin
                    void'(flush_token());
                    tok_state = ST_WAIT_EQ;
                end else if (c == CH_EQ) begin
                    void'(flush_token());
                    tok_state = ST_WAIT_QUOT;
                end else begin
                    append_char(c);
                end
            end
            ST_WAIT_EQ: begin
                if (c == CH_EQ) tok_state = ST_WAIT_QUOT;
                else if (!is_blank(c)) raise_error();
            end
            ST_WAIT_QUOT: begin
                if (c == CH_DQUOTE) begin
                    tok_state = ST_ATTR_VALUE;
                    tok_apos  = 1'b0;
                end else if (c == CH_APOS) begin
                    tok_state = ST_ATTR_VALUE;
                    tok_apos  = 1'b1;
                end else if (!is_blank(c)) begin
                    raise_error();
                end
            end
            ST_ATTR_VALUE: begin
                if ((c == CH_DQUOTE && !tok_apos) || (c == CH_APOS && tok_apos)) begin
                    void'(flush_token());
                    push_event(EV_END_ATTR, 1'b0, 8'h00, 1'b1);
                    tok_state = ST_ELEM_OPEN;
                end else begin
                    append_char(c);
                end
            end
            ST_CLOSE: begin
                if (c == CH_GT) tok_state = ST_CHARS;
                else if (!is_blank(c)) raise_error();
            end
            ST_CLOSE_NAME: begin
                if (is_blank(c)) begin
                    void'(flush_token());
                    tok_state = ST_CLOSE;
                end else if (c == CH_GT) begin
                    void'(flush_token());
                    tok_state = ST_CHARS;
                end else begin
                    append_char(c);
                end
            end
            ST_PI_CLOSE: begin
                if (c == CH_GT) tok_state = ST_CHARS;
                else raise_error();
            end
            default: begin
                tok_state = ST_ERROR;
            end
        endcase

        // chunk boundary drains pending text
        if (ce && (tok_state == ST_CHARS || tok_state == ST_ATTR_VALUE)) void'(flush_token());
    endfunction

    // Try a character on the shadow and roll back: would it end the parse?
    function automatic bit char_is_fatal(input logic [7:0] c, input bit ce);
        t_pstate     s_state = tok_state;
        int unsigned s_fill  = tok_fill;
        bit          s_in_pi = tok_in_pi;
        bit          s_apos  = tok_apos;
        logic [7:0]  s_text [TEXT_BUF_DEPTH];
        bit          fatal;
        s_text = tok_text;
        tokenise_char(c, ce);
        fatal = (tok_state == ST_ERROR) ||
                (tok_fill > TEXT_BUF_DEPTH - 2 &&
                 tok_state != ST_CHARS && tok_state != ST_ATTR_VALUE);
        tok_state = s_state;
        tok_fill  = s_fill;
        tok_in_pi = s_in_pi;
        tok_apos  = s_apos;
        tok_text  = s_text;
        return fatal;
    endfunction

    // ------------------------------------------------------------------
    // Character pickers
    // ------------------------------------------------------------------

    function automatic bit chunk_roll();
        return $urandom_range(9) == 0;
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] markup_char();
        case ($urandom_range(7))
            0:       return CH_LT;
            1:       return CH_GT;
            2:       return CH_SLASH;
            3:       return CH_QMARK;
            4:       return CH_EQ;
            5:       return CH_DQUOTE;
            6:       return CH_APOS;
            default: return blank_char();
        endcase
    endfunction

    function automatic logic [7:0] text_char(input logic [7:0] stop);
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (c == stop);
        return c;
    endfunction

    function automatic logic [7:0] name_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(255));
        end while (is_blank(c) || c == CH_GT || c == CH_SLASH || c == CH_QMARK || c == CH_EQ);
        return c;
    endfunction

    // Mostly short names, now and then one close to the buffer limit
    function automatic int unsigned name_len();
        return ($urandom_range(11) == 0) ? $urandom_range(TEXT_BUF_DEPTH - 2, 16)
                                          : $urandom_range(8, 1);
    endfunction

    // ------------------------------------------------------------------
    // Request driving and result checking
    // ------------------------------------------------------------------

    // Offer one character, hold it until taken, then predict its events
    task automatic send_char(input logic [7:0] c, input bit ce);
        if ($urandom_range(99) < src_idle_pct) begin
            chr_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        chr_if.valid     <= 1'b1;
        chr_if.char_byte <= c;
        chr_if.chunk_end <= ce;
        do @(posedge i_clk); while (chr_if.ready !== 1'b1);
        tokenise_char(c, ce);
        foreach (char_events[i]) expected_events.push_back(char_events[i]);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
    endtask

    task automatic send_name(input int unsigned len);
        repeat (len) send_char(name_char(), chunk_roll());
    endtask

    task automatic send_blanks();
        repeat ($urandom_range(2, 1)) send_char(blank_char(), chunk_roll());
    endtask

    // Drop valid and hold off until every predicted event has been seen
    task automatic wait_for_events();
        chr_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_events.size() != 0);
    endtask

    task automatic report_mismatch(input string what);
        if (err_count < REPORT_CAP) $display("[%0t] mismatch: %s", $time, what);
        err_count++;
    endtask

    // Take events at random and compare each with the oldest prediction
    initial begin : event_check
        evt_t want;
        evt_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && evt_if.valid === 1'b1 && evt_if.ready === 1'b1) begin
                if (expected_events.size() == 0) begin
                    report_mismatch($sformatf("unexpected event kind %0d byte %02h last %0b",
                                              evt_if.event_kind, evt_if.text_byte, evt_if.last));
                end else begin
                    want = expected_events.pop_front();
                    if (evt_if.event_kind !== want.kind)
                        report_mismatch($sformatf("event_kind %0d, want %0d",
                                                  evt_if.event_kind, want.kind));
                    if (evt_if.has_text !== want.has_text)
                        report_mismatch($sformatf("has_text %0b, want %0b",
                                                  evt_if.has_text, want.has_text));
                    if (evt_if.text_byte !== want.text_byte)
                        report_mismatch($sformatf("text_byte %02h, want %02h",
                                                  evt_if.text_byte, want.text_byte));
                    if (evt_if.last !== want.last)
                        report_mismatch($sformatf("last %0b, want %0b",
                                                  evt_if.last, want.last));
                end
            end
            evt_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Walk the tokeniser back to plain text by the shortest legal route
    task automatic settle_to_text();
        logic [7:0] c;
        while (tok_state != ST_CHARS && tok_state != ST_ERROR) begin
            case (tok_state)
                ST_ELEM_NAME:             c = (tok_fill == 0) ? CH_FILL : CH_GT;
                ST_ELEM_OPEN:             c = tok_in_pi ? CH_QMARK : CH_GT;
                ST_ATTR_NAME, ST_WAIT_EQ: c = CH_EQ;
                ST_WAIT_QUOT:             c = CH_DQUOTE;
                ST_ATTR_VALUE:            c = tok_apos ? CH_APOS : CH_DQUOTE;
                default:                  c = CH_GT;
            endcase
            send_char(c, chunk_roll());
        end
    endtask

    // Open tag or processing instruction with random attributes
    task automatic send_tag(input bit pi);
        int unsigned n_attr;
        int unsigned len;
        logic [7:0]  quote;
        n_attr = $urandom_range(3);
        send_char(CH_LT, chunk_roll());
        if (pi) send_char(CH_QMARK, chunk_roll());
        send_name(name_len());
        if (n_attr != 0 || pi || $urandom_range(3) == 0) send_blanks();
        repeat (n_attr) begin
            send_name(name_len());
            if ($urandom_range(2) == 0) send_blanks();
            send_char(CH_EQ, chunk_roll());
            if ($urandom_range(3) == 0) send_blanks();
            quote = ($urandom_range(1) == 0) ? CH_APOS : CH_DQUOTE;
            send_char(quote, chunk_roll());
            len = ($urandom_range(11) == 0) ? $urandom_range(45, 28) : $urandom_range(6);
            repeat (len) send_char(text_char(quote), chunk_roll());
            send_char(quote, chunk_roll());
            if ($urandom_range(1) == 0) send_blanks();
        end
        if (pi) begin
            send_char(CH_QMARK, chunk_roll());
            send_char(CH_GT, chunk_roll());
        end else if ($urandom_range(2) == 0) begin
            send_char(CH_SLASH, chunk_roll());
            if ($urandom_range(2) == 0) send_blanks();
            send_char(CH_GT, chunk_roll());
        end else begin
            send_char(CH_GT, chunk_roll());
        end
    endtask

    // One random piece of markup, starting and ending in plain text
    task automatic send_fragment();
        int unsigned pick;
        int unsigned len;
        logic [7:0]  c;
        bit          ce;
        pick = $urandom_range(99);
        if (pick < 12) begin
            // stray characters in whatever state, skipping any that would kill the parse
            len = $urandom_range(6, 1);
            repeat (len) begin
                c  = ($urandom_range(1) == 0) ? markup_char() : 8'($urandom_range(255));
                ce = chunk_roll();
                if (!char_is_fatal(c, ce)) send_char(c, ce);
            end
            settle_to_text();
        end else if (pick < 40) begin
            // text run, sometimes long enough to force an early flush
            len = ($urandom_range(9) == 0) ? $urandom_range(45, 28) : $urandom_range(8);
            repeat (len) send_char(text_char(CH_LT), chunk_roll());
        end else if (pick < 72) begin
            send_tag(1'b0);
        end else if (pick < 86) begin
            // closing tag, sometimes nameless or with trailing blanks
            send_char(CH_LT, chunk_roll());
            send_char(CH_SLASH, chunk_roll());
            send_name(($urandom_range(7) == 0) ? 0 : name_len());
            if ($urandom_range(2) == 0) send_blanks();
            send_char(CH_GT, chunk_roll());
        end else begin
            send_tag(1'b1);
        end
    endtask

    task automatic test_directed_tokens();
        // extreme byte values as text, drained by a chunk boundary
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        // both quote styles, an empty value and an empty-element close
        send_text("<a b='' c=\"1\"/>");
        // closing tag with no name
        send_text("</>");
        // processing instruction: swallowed without events
        send_text("<?p?>");
    endtask

    task automatic test_random_markup(input int unsigned n_chars, input bit hold_off);
        int unsigned stop_at;
        int unsigned pause_at;
        stop_at  = chars_sent + n_chars;
        pause_at = chars_sent + n_chars / 2;
        while (chars_sent < stop_at) begin
            if (hold_off && chars_sent >= pause_at) begin
                wait_for_events();
                hold_off = 1'b0;
            end
            send_fragment();
        end
    endtask

    // Errors are sticky, so one route is taken per run and the rest is dropped
    task automatic test_sticky_error();
        err_route_t route;
        route = err_route_t'($urandom_range(8));
        case (route)
            ER_EMPTY_NAME:      send_text("<>");
            ER_NAME_OVERFLOW: begin
                send_char(CH_LT, 1'b0);
                repeat (TEXT_BUF_DEPTH) send_char(CH_FILL, 1'b0);
            end
            ER_NO_EQUALS:       send_text("<a b c");
            ER_BAD_EMPTY_CLOSE: send_text("<a/x");
            ER_PI_PLAIN_CLOSE:  send_text("<?p >");
            ER_QMARK_NO_PI:     send_text("<a ?");
            ER_BAD_CLOSE:       send_text("</a b");
            ER_BAD_PI_CLOSE:    send_text("<?p ?x");
            default:            send_text("<a b=x");
        endcase
        repeat ($urandom_range(6, 3)) send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    // ------------------------------------------------------------------
    // Clock, watchdog and test sequence
    // ------------------------------------------------------------------

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_xml_sax_tokenizer_top: errors");
        $finish;
    end

    initial begin
        tok_state = ST_CHARS;
        tok_fill  = 0;
        tok_in_pi = 1'b0;
        tok_apos  = 1'b0;
        foreach (tok_text[i]) tok_text[i] = 8'h00;

        i_rst_n          <= 1'b0;
        chr_if.valid     <= 1'b0;
        chr_if.char_byte <= 8'h00;
        chr_if.chunk_end <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender mostly busy, receiver mostly stalled
        src_idle_pct = 7;
        snk_idle_pct = 71;
        test_directed_tokens();
        test_random_markup(PHASE_CHARS, 1'b1);

        // sender mostly idle, receiver mostly ready
        src_idle_pct = 71;
        snk_idle_pct = 7;
        test_random_markup(PHASE_CHARS, 1'b0);

        // full rate on both sides
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_markup(PHASE_CHARS, 1'b0);
        test_sticky_error();

        wait_for_events();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_xml_sax_tokenizer_top: clean");
        end else begin
            $display("tb_xml_sax_tokenizer_top: errors");
        end
        $finish;
    end

endmodule
